FILE: hw/rtl/tlpg_pkg.sv
// ---------------------------------------------------------------------------
// Tri-light pattern generator package
// Shared types, pattern and register codes, command decode table.
// ---------------------------------------------------------------------------
`default_nettype none

package tlpg_pkg;

  // serial divider geometry: two quotient bits per cycle
  localparam int DvdW    = 32;
  localparam int DvsW    = 17;
  localparam int DigW    = 2;
  localparam int StepCnt = DvdW / DigW;
  localparam int CntW    = $clog2(StepCnt);

  localparam int CfgW    = 16;
  localparam int PatW    = 5;

  typedef struct packed {
    logic            done;
    logic            dig_vld;
    logic [DigW-1:0] digit;
  } div_stat_t;

  // register indexes
  localparam logic [1:0] RegInitStep  = 2'd0;
  localparam logic [1:0] RegFloorStep = 2'd1;
  localparam logic [1:0] RegSpeedup   = 2'd2;
  localparam logic [1:0] RegSlowHalf  = 2'd3;

  localparam logic [CfgW-1:0] InitStepRst  = 16'd300;
  localparam logic [CfgW-1:0] FloorStepRst = 16'd30;
  localparam logic [CfgW-1:0] SpeedupRst   = 16'd1000;
  localparam logic [CfgW-1:0] SlowHalfRst  = 16'd500;

  // patterns
  localparam logic [PatW-1:0] PatOff      = 5'd0;
  localparam logic [PatW-1:0] PatGrnOn    = 5'd1;
  localparam logic [PatW-1:0] PatGrnSlow  = 5'd2;
  localparam logic [PatW-1:0] PatGrnFast  = 5'd3;
  localparam logic [PatW-1:0] PatYelOn    = 5'd4;
  localparam logic [PatW-1:0] PatYelSlow  = 5'd5;
  localparam logic [PatW-1:0] PatYelFast  = 5'd6;
  localparam logic [PatW-1:0] PatRedOn    = 5'd7;
  localparam logic [PatW-1:0] PatRedSlow  = 5'd8;
  localparam logic [PatW-1:0] PatRedFast  = 5'd9;
  localparam logic [PatW-1:0] PatRedGrn   = 5'd10;
  localparam logic [PatW-1:0] PatRedYel   = 5'd11;
  localparam logic [PatW-1:0] PatYelGrn   = 5'd12;
  localparam logic [PatW-1:0] PatRotRyg   = 5'd13;
  localparam logic [PatW-1:0] PatRotGyr   = 5'd14;
  localparam logic [PatW-1:0] PatAllOn    = 5'd15;
  localparam logic [PatW-1:0] PatAllSlow  = 5'd16;
  localparam logic [PatW-1:0] PatAllFast  = 5'd17;

  // command bytes (ASCII letters)
  localparam logic [7:0] CmdGrnOn   = 8'h41;  // A
  localparam logic [7:0] CmdGrnFast = 8'h42;  // B
  localparam logic [7:0] CmdGrnSlow = 8'h43;  // C
  localparam logic [7:0] CmdYelOn   = 8'h44;  // D
  localparam logic [7:0] CmdYelFast = 8'h45;  // E
  localparam logic [7:0] CmdYelSlow = 8'h46;  // F
  localparam logic [7:0] CmdRedOn   = 8'h47;  // G
  localparam logic [7:0] CmdRedFast = 8'h48;  // H
  localparam logic [7:0] CmdRedSlow = 8'h49;  // I
  localparam logic [7:0] CmdRedGrn  = 8'h4A;  // J
  localparam logic [7:0] CmdRedYel  = 8'h4C;  // L
  localparam logic [7:0] CmdYelGrn  = 8'h4E;  // N
  localparam logic [7:0] CmdRotRyg  = 8'h51;  // Q
  localparam logic [7:0] CmdRotGyr  = 8'h52;  // R
  localparam logic [7:0] CmdOff     = 8'h54;  // T
  localparam logic [7:0] CmdAllOn   = 8'h55;  // U
  localparam logic [7:0] CmdAllFast = 8'h56;  // V
  localparam logic [7:0] CmdAllSlow = 8'h57;  // W

  // lamp codes: bit 2 red, bit 1 yellow, bit 0 green
  localparam logic [2:0] LampNone = 3'b000;
  localparam logic [2:0] LampGrn  = 3'b001;
  localparam logic [2:0] LampYel  = 3'b010;
  localparam logic [2:0] LampRed  = 3'b100;
  localparam logic [2:0] LampAll  = 3'b111;

  // returns {hit, pattern}
  function automatic logic [PatW:0] cmd_decode(input logic [7:0] code);
    logic [PatW:0] res;
    case (code)
      CmdGrnOn:   res = {1'b1, PatGrnOn};
      CmdGrnFast: res = {1'b1, PatGrnFast};
      CmdGrnSlow: res = {1'b1, PatGrnSlow};
      CmdYelOn:   res = {1'b1, PatYelOn};
      CmdYelFast: res = {1'b1, PatYelFast};
      CmdYelSlow: res = {1'b1, PatYelSlow};
      CmdRedOn:   res = {1'b1, PatRedOn};
      CmdRedFast: res = {1'b1, PatRedFast};
      CmdRedSlow: res = {1'b1, PatRedSlow};
      CmdRedGrn:  res = {1'b1, PatRedGrn};
      CmdRedYel:  res = {1'b1, PatRedYel};
      CmdYelGrn:  res = {1'b1, PatYelGrn};
      CmdRotRyg:  res = {1'b1, PatRotRyg};
      CmdRotGyr:  res = {1'b1, PatRotGyr};
      CmdOff:     res = {1'b1, PatOff};
      CmdAllOn:   res = {1'b1, PatAllOn};
      CmdAllFast: res = {1'b1, PatAllFast};
      CmdAllSlow: res = {1'b1, PatAllSlow};
      default:    res = {1'b0, PatOff};
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tlpg_div.sv
// ---------------------------------------------------------------------------
// Serial divider
// Restoring division, two quotient bits per cycle, quotient digits streamed.
// ---------------------------------------------------------------------------
`default_nettype none

module tlpg_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tlpg_pkg::DvdW-1:0]  dividend,
  input  wire logic [tlpg_pkg::DvsW-1:0]  divisor,
  output logic      [tlpg_pkg::DvdW-1:0]  quotient,
  output logic      [tlpg_pkg::DvsW-1:0]  remainder,
  output tlpg_pkg::div_stat_t             stat
);
  import tlpg_pkg::*;

  logic            busy_r;
  logic            done_r;
  logic [CntW-1:0] cnt_r;
  logic [DvdW-1:0] dvd_r;
  logic [DvdW-1:0] quo_r;
  logic [DvsW-1:0] rem_r;
  logic [DvsW-1:0] dvs_r;

  logic [DvsW:0]   t1, r1, t2, r2;
  logic            ge1, ge2;
  logic            last;

  // two chained restoring steps
  always_comb begin
    t1  = {rem_r, dvd_r[DvdW-1]};
    ge1 = t1 >= {1'b0, dvs_r};
    r1  = ge1 ? t1 - {1'b0, dvs_r} : t1;
    t2  = {r1[DvsW-1:0], dvd_r[DvdW-2]};
    ge2 = t2 >= {1'b0, dvs_r};
    r2  = ge2 ? t2 - {1'b0, dvs_r} : t2;
  end

  assign last = cnt_r == CntW'(StepCnt - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DvdW-DigW-1:0], {DigW{1'b0}}};
      rem_r <= r2[DvsW-1:0];
      quo_r <= {quo_r[DvdW-DigW-1:0], ge1, ge2};
    end
  end

  assign quotient      = quo_r;
  assign remainder     = rem_r;
  assign stat.done     = done_r;
  assign stat.dig_vld  = busy_r;
  assign stat.digit    = {ge1, ge2};

  // remainder must stay below the divisor once a run completes
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder out of range");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted during a run");

endmodule

`default_nettype wire

FILE: hw/rtl/tri_light_pattern_generator.sv
// ---------------------------------------------------------------------------
// Tri-light pattern generator
// Command decode, elapsed-time dividers and lamp rendering for R/Y/G lamps.
// ---------------------------------------------------------------------------
// A new input transfer is stalled (in_stall) until the item has gone through
//   two back-to-back passes of the 2-bit-per-cycle serial divider (16 steps
//   each, 32-bit elapsed time) and the write state.
// A finished result waits in the output register; the next input transfer is
//   taken meanwhile, and the result is only overwritten once transferred.
// Reset (rst_n low, synchronous): pattern off, start time 0, registers to
//   their defaults, no result pending.
`default_nettype none

module tri_light_pattern_generator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_mode,
  input  wire logic [7:0]                 in_command_code,
  input  wire logic [31:0]                in_now_ms,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_red_on,
  output logic                            out_yellow_on,
  output logic                            out_green_on,
  output logic                            out_command_accepted,
  output logic [tlpg_pkg::PatW-1:0]       out_active_pattern,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [3:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tlpg_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an input transfer
  localparam logic [2:0] S_EL   = 3'd1;  // elapsed time, launch first pass
  localparam logic [2:0] S_P1   = 3'd2;  // speedup drop and slow remainder
  localparam logic [2:0] S_FS   = 3'd3;  // launch fast-step pass
  localparam logic [2:0] S_P2   = 3'd4;  // elapsed / fast step
  localparam logic [2:0] S_WR   = 3'd5;  // load output register

  // ---- configuration registers ----
  logic [CfgW-1:0] init_step_r, floor_step_r, speedup_r, slow_half_r;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_step_r  <= InitStepRst;
      floor_step_r <= FloorStepRst;
      speedup_r    <= SpeedupRst;
      slow_half_r  <= SlowHalfRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegInitStep:  init_step_r  <= pwdata[CfgW-1:0];
        RegFloorStep: floor_step_r <= pwdata[CfgW-1:0];
        RegSpeedup:   speedup_r    <= pwdata[CfgW-1:0];
        RegSlowHalf:  slow_half_r  <= pwdata[CfgW-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegInitStep:  prdata = {16'd0, init_step_r};
      RegFloorStep: prdata = {16'd0, floor_step_r};
      RegSpeedup:   prdata = {16'd0, speedup_r};
      RegSlowHalf:  prdata = {16'd0, slow_half_r};
      default:      prdata = '0;
    endcase
  end

  // a zero register value behaves as one
  logic [CfgW-1:0] init1, flr1, spd1, sh1;
  assign init1 = (init_step_r  == '0) ? CfgW'(1) : init_step_r;
  assign flr1  = (floor_step_r == '0) ? CfgW'(1) : floor_step_r;
  assign spd1  = (speedup_r    == '0) ? CfgW'(1) : speedup_r;
  assign sh1   = (slow_half_r  == '0) ? CfgW'(1) : slow_half_r;

  // ---- item state ----
  logic [2:0]      state_r, state_nxt;
  logic [PatW-1:0] pat_r;
  logic [31:0]     start_r;
  logic [31:0]     now_r;
  logic [31:0]     el_r;
  logic            acc_r;
  logic [CfgW-1:0] fs_r;
  logic            slow_r;     // inside lit half of the slow blink
  logic            q0_r;       // parity of elapsed / fast step
  logic [1:0]      m3_r;       // elapsed / fast step, mod 3

  logic            in_xfer, out_xfer;
  logic [PatW:0]   cmd;
  logic [31:0]     el_diff;

  assign in_stall = state_r != S_IDLE;
  assign in_xfer  = in_valid && !in_stall;
  assign cmd      = cmd_decode(in_command_code);
  assign el_diff  = now_r - start_r;   // wraps, as the time counter does

  // ---- dividers: A does drop then fast step, B the slow-blink remainder ----
  logic            a_start, b_start;
  logic [DvdW-1:0] a_dvd;
  logic [DvsW-1:0] a_dvs;
  logic [DvdW-1:0] a_quo;
  logic [DvsW-1:0] b_rem;
  div_stat_t       a_stat, b_stat;

  assign a_start = (state_r == S_EL) || (state_r == S_FS);
  assign b_start = state_r == S_EL;
  assign a_dvd   = (state_r == S_EL) ? el_diff : el_r;
  assign a_dvs   = (state_r == S_EL) ? {1'b0, spd1} : {1'b0, fs_r};

  tlpg_div u_div_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (a_start),
    .dividend  (a_dvd),
    .divisor   (a_dvs),
    .quotient  (a_quo),
    .remainder (),
    .stat      (a_stat)
  );

  tlpg_div u_div_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (b_start),
    .dividend  (el_diff),
    .divisor   ({sh1, 1'b0}),
    .quotient  (),
    .remainder (b_rem),
    .stat      (b_stat)
  );

  // fast step from the speedup drop, clamped at the floor
  logic [CfgW-1:0] gap;
  logic [CfgW-1:0] fs_nxt;
  always_comb begin
    gap = init1 - flr1;
    if (flr1 >= init1 || a_quo >= {16'd0, gap}) begin
      fs_nxt = flr1;
    end else begin
      fs_nxt = init1 - a_quo[CfgW-1:0];
    end
  end

  // 4 = 1 mod 3, so each base-4 digit just adds
  logic [2:0] m3_sum;
  logic [1:0] m3_nxt;
  always_comb begin
    m3_sum = {1'b0, m3_r} + {1'b0, a_stat.digit};
    m3_nxt = (m3_sum >= 3'd3) ? 2'(m3_sum - 3'd3) : m3_sum[1:0];
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_EL;
      S_EL:   state_nxt = S_P1;
      S_P1:   if (a_stat.done) state_nxt = S_FS;
      S_FS:   state_nxt = S_P2;
      S_P2:   if (a_stat.done) state_nxt = S_WR;
      S_WR:   if (!out_valid || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pat_r   <= PatOff;
      start_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer && in_mode && cmd[PatW]) begin
        pat_r   <= cmd[PatW-1:0];
        start_r <= in_now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r <= in_now_ms;
      acc_r <= in_mode && cmd[PatW];
    end
    if (state_r == S_EL) begin
      el_r <= el_diff;
    end
    if (state_r == S_P1 && a_stat.done) begin
      fs_r   <= fs_nxt;
      slow_r <= b_rem < {1'b0, sh1};
    end
    if (state_r == S_FS) begin
      m3_r <= 2'd0;
    end else if (state_r == S_P2 && a_stat.dig_vld) begin
      m3_r <= m3_nxt;
    end
    if (state_r == S_P2 && a_stat.done) begin
      q0_r <= a_quo[0];
    end
  end

  // ---- rendering ----
  // fast blink lit while elapsed / step is even (first half of 2*step)
  logic       fast;
  logic [2:0] lamp;
  assign fast = !q0_r;

  always_comb begin
    case (pat_r)
      PatGrnOn:   lamp = LampGrn;
      PatGrnSlow: lamp = slow_r ? LampGrn : LampNone;
      PatGrnFast: lamp = fast   ? LampGrn : LampNone;
      PatYelOn:   lamp = LampYel;
      PatYelSlow: lamp = slow_r ? LampYel : LampNone;
      PatYelFast: lamp = fast   ? LampYel : LampNone;
      PatRedOn:   lamp = LampRed;
      PatRedSlow: lamp = slow_r ? LampRed : LampNone;
      PatRedFast: lamp = fast   ? LampRed : LampNone;
      PatRedGrn:  lamp = q0_r ? LampGrn : LampRed;
      PatRedYel:  lamp = q0_r ? LampYel : LampRed;
      PatYelGrn:  lamp = q0_r ? LampGrn : LampYel;
      PatRotRyg:  lamp = (m3_r == 2'd0) ? LampRed :
                         (m3_r == 2'd1) ? LampYel : LampGrn;
      PatRotGyr:  lamp = (m3_r == 2'd0) ? LampGrn :
                         (m3_r == 2'd1) ? LampYel : LampRed;
      PatAllOn:   lamp = LampAll;
      PatAllSlow: lamp = slow_r ? LampAll : LampNone;
      PatAllFast: lamp = fast   ? LampAll : LampNone;
      default:    lamp = LampNone;
    endcase
  end

  // ---- output register ----
  logic            out_valid_r;
  logic            out_load;
  logic [2:0]      out_lamp_r;
  logic            out_acc_r;
  logic [PatW-1:0] out_pat_r;

  assign out_xfer = out_valid_r && !out_stall;
  assign out_load = (state_r == S_WR) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lamp_r <= lamp;
      out_acc_r  <= acc_r;
      out_pat_r  <= pat_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_red_on           = out_lamp_r[2];
  assign out_yellow_on        = out_lamp_r[1];
  assign out_green_on         = out_lamp_r[0];
  assign out_command_accepted = out_acc_r;
  assign out_active_pattern   = out_pat_r;

  // ---- assertions ----
  a_both_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.done |-> (a_stat.done && state_r == S_P1))
    else $error("slow-blink divider out of step with drop divider");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    a_stat.done |-> (state_r == S_P1 || state_r == S_P2))
    else $error("divider finished outside a pass");

  a_fs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P2) |-> (fs_r != '0))
    else $error("zero fast step used as divisor");

  a_acc_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR && acc_r) |-> (start_r == now_r && el_r == '0))
    else $error("accepted command did not restart the pattern");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WR))
    else $error("result raised outside the write state");

endmodule

`default_nettype wire
